/* src/sscr_pkg.sv */
// sscr_pkg: shared types and constants of the serial controller register block
// no dependencies
package sscr_pkg;

	localparam int OFFSET_BITS = 14;

	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_MEM   = 2'd2;

	localparam logic [8:0] REG_CR    = 9'h000;
	localparam logic [8:0] REG_CMR   = 9'h004;
	localparam logic [8:0] REG_RCMR  = 9'h010;
	localparam logic [8:0] REG_RFMR  = 9'h014;
	localparam logic [8:0] REG_TCMR  = 9'h018;
	localparam logic [8:0] REG_TFMR  = 9'h01c;
	localparam logic [8:0] REG_RHR   = 9'h020;
	localparam logic [8:0] REG_THR   = 9'h024;
	localparam logic [8:0] REG_RSHR  = 9'h030;
	localparam logic [8:0] REG_TSHR  = 9'h034;
	localparam logic [8:0] REG_RC0R  = 9'h038;
	localparam logic [8:0] REG_RC1R  = 9'h03c;
	localparam logic [8:0] REG_SR    = 9'h040;
	localparam logic [8:0] REG_IER   = 9'h044;
	localparam logic [8:0] REG_IDR   = 9'h048;
	localparam logic [8:0] REG_IMR   = 9'h04c;
	localparam logic [8:0] REG_VER   = 9'h0fc;
	localparam logic [8:0] REG_RPR   = 9'h100;
	localparam logic [8:0] REG_RCR   = 9'h104;
	localparam logic [8:0] REG_TPR   = 9'h108;
	localparam logic [8:0] REG_TCR   = 9'h10c;
	localparam logic [8:0] REG_RNPR  = 9'h110;
	localparam logic [8:0] REG_RNCR  = 9'h114;
	localparam logic [8:0] REG_TNPR  = 9'h118;
	localparam logic [8:0] REG_TNCR  = 9'h11c;
	localparam logic [8:0] REG_PTCR  = 9'h120;
	localparam logic [8:0] REG_PTSR  = 9'h124;

	localparam logic [31:0] VERSION = 32'h0000_0100;
	localparam int LOOP_BIT = 5;

	typedef struct packed {
		logic [1:0]  action;
		logic [OFFSET_BITS-1:0] offset;
		logic [31:0] write_data;
		logic [31:0] memory_data;
	} req_in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq;
		logic        tx_dma_request;
		logic        rx_dma_request;
		logic        mem_write_valid;
		logic [31:0] mem_write_address;
		logic [31:0] mem_write_data;
		logic [2:0]  mem_write_bytes;
		logic        mem_read_valid;
		logic [31:0] mem_read_address;
		logic [2:0]  mem_read_bytes;
	} req_out_t;

	typedef struct packed {
		logic rx_on;
		logic tx_on;
		logic rx_dma;
		logic tx_dma;
		logic rx_pend;
		logic ovr;
		logic endrx;
		logic endtx;
		logic rearm;
	} flags_t;

	typedef struct packed {
		logic [11:0]     clock_mode;
		logic [3:0][31:0] mode;
		logic [31:0]     rx_holding;
		logic [3:0][15:0] sync_cmp;
		logic [31:0]     irq_mask;
		logic [3:0][31:0] ptr;
		logic [3:0][31:0] cnt;
		flags_t          flags;
		logic            tx_read_pending;
	} regs_t;

	function automatic logic [2:0] frame_bytes(input logic [31:0] fmr);
		logic [5:0] bits;
		bits = {1'b0, fmr[4:0]} + 6'd1;
		if (bits <= 6'd8) return 3'd1;
		else if (bits <= 6'd16) return 3'd2;
		else return 3'd4;
	endfunction

	function automatic logic [31:0] byte_mask(input logic [2:0] n);
		case (n)
			3'd1:    return 32'h0000_00ff;
			3'd2:    return 32'h0000_ffff;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	function automatic logic [31:0] status_word(input regs_t r);
		logic [31:0] s;
		s = 32'h3;
		s[2]  = (r.cnt[1] == '0) || r.flags.endtx;
		s[3]  = (r.cnt[1] == '0) && (r.cnt[3] == '0);
		s[4]  = r.flags.rx_pend;
		s[5]  = r.flags.ovr;
		s[6]  = (r.cnt[0] == '0) || r.flags.endrx;
		s[7]  = (r.cnt[0] == '0) && (r.cnt[2] == '0);
		s[16] = r.flags.tx_on;
		s[17] = r.flags.rx_on;
		return s;
	endfunction

endpackage

/* src/sscr_core.sv */
// sscr_core: next-state and result logic for one request
// depends on sscr_pkg
module sscr_core
	import sscr_pkg::*;
(
	input  regs_t    cur,
	input  req_in_t  req,
	output regs_t    nxt,
	output req_out_t res
);

	// promote next pair into current pair
	function automatic regs_t promote(input regs_t r, input int c, input int n, input logic en);
		regs_t t;
		t = r;
		if (en && t.cnt[c] == '0 && t.cnt[n] != '0) begin
			t.ptr[c] = t.ptr[n];
			t.cnt[c] = t.cnt[n];
			t.ptr[n] = '0;
			t.cnt[n] = '0;
		end
		return t;
	endfunction

	always_comb begin
		regs_t       r;
		req_out_t    o;
		logic [8:0]  ofs;
		logic        hit;
		logic [31:0] v;
		logic [2:0]  n;
		logic        take;
		logic [31:0] word;
		logic [2:0]  rn;

		r = cur;
		o = '0;
		take = 1'b0;
		word = '0;
		n = '0;
		rn = '0;
		v = req.write_data;
		r.flags.rearm = 1'b0;
		ofs = req.offset[8:0];
		hit = (req.offset[OFFSET_BITS-1:9] == '0);

		if (req.action == ACT_READ) begin
			if (hit) begin
				case (ofs)
					REG_CMR:  o.read_data = {20'd0, r.clock_mode};
					REG_RCMR: o.read_data = r.mode[0];
					REG_RFMR: o.read_data = r.mode[1];
					REG_TCMR: o.read_data = r.mode[2];
					REG_TFMR: o.read_data = r.mode[3];
					REG_RHR: begin
						o.read_data = r.rx_holding;
						r.flags.rx_pend = 1'b0;
						r.flags.ovr = 1'b0;
					end
					REG_RSHR: o.read_data = {16'd0, r.sync_cmp[0]};
					REG_TSHR: o.read_data = {16'd0, r.sync_cmp[1]};
					REG_RC0R: o.read_data = {16'd0, r.sync_cmp[2]};
					REG_RC1R: o.read_data = {16'd0, r.sync_cmp[3]};
					REG_SR: begin
						o.read_data = status_word(r);
						r.flags.endrx = 1'b0;
						r.flags.endtx = 1'b0;
						r.flags.ovr = 1'b0;
					end
					REG_IMR:  o.read_data = r.irq_mask;
					REG_VER:  o.read_data = VERSION;
					REG_RPR:  o.read_data = r.ptr[0];
					REG_RCR:  o.read_data = r.cnt[0];
					REG_TPR:  o.read_data = r.ptr[1];
					REG_TCR:  o.read_data = r.cnt[1];
					REG_RNPR: o.read_data = r.ptr[2];
					REG_RNCR: o.read_data = r.cnt[2];
					REG_TNPR: o.read_data = r.ptr[3];
					REG_TNCR: o.read_data = r.cnt[3];
					REG_PTSR: o.read_data = {23'd0, r.flags.tx_dma, 7'd0, r.flags.rx_dma};
					default:  o.read_data = '0;
				endcase
			end
		end else if (req.action == ACT_WRITE) begin
			if (hit) begin
				case (ofs)
					REG_CR: begin
						if (v[15]) begin
							r = '0;
						end else begin
							if (v[0]) r.flags.rx_on = 1'b1;
							if (v[1]) r.flags.rx_on = 1'b0;
							if (v[8]) r.flags.tx_on = 1'b1;
							if (v[9]) begin
								r.flags.tx_on = 1'b0;
								r.flags.rearm = 1'b0;
							end
						end
					end
					REG_CMR:  r.clock_mode = v[11:0];
					REG_RCMR: r.mode[0] = v;
					REG_RFMR: r.mode[1] = v;
					REG_TCMR: r.mode[2] = v;
					REG_TFMR: r.mode[3] = v;
					REG_THR: begin
						if (r.flags.tx_on) begin
							if (r.mode[1][LOOP_BIT]) begin
								take = 1'b1;
								word = v;
							end
							r.flags.rearm = 1'b1;
						end
					end
					REG_RSHR: r.sync_cmp[0] = v[15:0];
					REG_TSHR: r.sync_cmp[1] = v[15:0];
					REG_RC0R: r.sync_cmp[2] = v[15:0];
					REG_RC1R: r.sync_cmp[3] = v[15:0];
					REG_IER:  r.irq_mask = r.irq_mask | v;
					REG_IDR:  r.irq_mask = r.irq_mask & ~v;
					REG_RPR:  r.ptr[0] = v;
					REG_RCR:  r.cnt[0] = v;
					REG_TPR:  r.ptr[1] = v;
					REG_TCR:  r.cnt[1] = v;
					REG_RNPR: r.ptr[2] = v;
					REG_RNCR: begin
						r.cnt[2] = v;
						r = promote(r, 0, 2, r.flags.rx_dma);
					end
					REG_TNPR: r.ptr[3] = v;
					REG_TNCR: r.cnt[3] = v;
					REG_PTCR: begin
						if (v[0]) begin
							r.flags.rx_dma = 1'b1;
							r = promote(r, 0, 2, 1'b1);
						end
						if (v[1]) r.flags.rx_dma = 1'b0;
						if (v[8]) r.flags.tx_dma = 1'b1;
						if (v[9]) r.flags.tx_dma = 1'b0;
					end
					default: ;
				endcase
			end
		end else if (req.action == ACT_MEM) begin
			if (r.tx_read_pending) begin
				r.tx_read_pending = 1'b0;
				if (r.flags.tx_dma && r.flags.tx_on && r.cnt[1] != '0) begin
					n = frame_bytes(r.mode[3]);
					r.ptr[1] = r.ptr[1] + {29'd0, n};
					r.cnt[1] = r.cnt[1] - 32'd1;
					// loopback into receive, before end-of-transmit handling
					if (r.mode[1][LOOP_BIT] && r.flags.rx_on) begin
						take = 1'b1;
						word = req.memory_data & byte_mask(n);
					end
				end
			end
		end

		// receive path
		if (take && r.flags.rx_on) begin
			rn = frame_bytes(r.mode[1]);
			r = promote(r, 0, 2, r.flags.rx_dma);
			if (r.flags.rx_dma && r.cnt[0] != '0) begin
				o.mem_write_valid = 1'b1;
				o.mem_write_address = r.ptr[0];
				o.mem_write_data = word & byte_mask(rn);
				o.mem_write_bytes = rn;
				r.ptr[0] = r.ptr[0] + {29'd0, rn};
				r.cnt[0] = r.cnt[0] - 32'd1;
				if (r.cnt[0] == '0) begin
					r.flags.endrx = 1'b1;
					r = promote(r, 0, 2, r.flags.rx_dma);
				end
			end else begin
				if (r.flags.rx_pend) r.flags.ovr = 1'b1;
				r.rx_holding = word;
				r.flags.rx_pend = 1'b1;
			end
		end

		// end of transmit buffer after a fetch
		if (n != '0 && r.cnt[1] == '0) begin
			r.flags.endtx = 1'b1;
		end

		r = promote(r, 1, 3, r.flags.tx_dma);
		if (!r.tx_read_pending && r.flags.tx_dma && r.flags.tx_on && r.cnt[1] != '0) begin
			o.mem_read_valid = 1'b1;
			o.mem_read_address = r.ptr[1];
			o.mem_read_bytes = frame_bytes(r.mode[3]);
			r.tx_read_pending = 1'b1;
		end

		o.irq = (status_word(r) & r.irq_mask) != '0;
		o.tx_dma_request = r.flags.tx_on && !r.flags.rearm && !r.flags.rx_pend;
		o.rx_dma_request = r.flags.rx_on && r.flags.rx_pend;

		nxt = r;
		res = o;
	end

endmodule

/* src/sync_serial_ctrl_regs_pdc.sv */
// sync_serial_ctrl_regs_pdc: top level, state registers and result register
// depends on sscr_pkg and sscr_core
//
//  port   | dir | handshake        | payload
//  -------+-----+------------------+-----------
//  in     | in  | in_valid/in_stall | req_in_t
//  out    | out | out_valid/out_stall | req_out_t
//
// one request per cycle while the result is not stalled: the register update and
// result are computed combinationally from the state registers and captured in the result register.
// a request is taken whenever the result register is empty or being drained.
// reset clears all state registers and the result valid.
// while out_stall is high and a result is valid, the result holds and in_stall rises.
module sync_serial_ctrl_regs_pdc
	import sscr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  req_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output req_out_t out_data
);

	regs_t    regs_q;
	regs_t    regs_next;
	req_out_t res;
	logic     take;

	assign in_stall = out_valid && out_stall;
	assign take = in_valid && !in_stall;

	sscr_core u_core (
		.cur (regs_q),
		.req (in_data),
		.nxt (regs_next),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (take) regs_q <= regs_next;
			if (take) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) out_data <= res;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result dropped under stall");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!regs_q.flags.ovr || regs_q.flags.rx_pend || $past(regs_q.flags.ovr))
		else $error("overrun without pending");
	a_rd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.mem_read_valid |-> regs_q.tx_read_pending || take)
		else $error("read issued without pending mark");

endmodule

/* tb/sscr_scoreboard.sv */
// sscr_scoreboard: predictor and result checker for the serial controller register block
// depends on sscr_pkg for the request and result types
class sscr_scoreboard;
	localparam logic [8:0] OFS_CR   = 9'h000;
	localparam logic [8:0] OFS_CMR  = 9'h004;
	localparam logic [8:0] OFS_RCMR = 9'h010;
	localparam logic [8:0] OFS_RFMR = 9'h014;
	localparam logic [8:0] OFS_TCMR = 9'h018;
	localparam logic [8:0] OFS_TFMR = 9'h01c;
	localparam logic [8:0] OFS_RHR  = 9'h020;
	localparam logic [8:0] OFS_THR  = 9'h024;
	localparam logic [8:0] OFS_RSHR = 9'h030;
	localparam logic [8:0] OFS_TSHR = 9'h034;
	localparam logic [8:0] OFS_RC0R = 9'h038;
	localparam logic [8:0] OFS_RC1R = 9'h03c;
	localparam logic [8:0] OFS_SR   = 9'h040;
	localparam logic [8:0] OFS_IER  = 9'h044;
	localparam logic [8:0] OFS_IDR  = 9'h048;
	localparam logic [8:0] OFS_IMR  = 9'h04c;
	localparam logic [8:0] OFS_VER  = 9'h0fc;
	localparam logic [8:0] OFS_RPR  = 9'h100;
	localparam logic [8:0] OFS_RCR  = 9'h104;
	localparam logic [8:0] OFS_TPR  = 9'h108;
	localparam logic [8:0] OFS_TCR  = 9'h10c;
	localparam logic [8:0] OFS_RNPR = 9'h110;
	localparam logic [8:0] OFS_RNCR = 9'h114;
	localparam logic [8:0] OFS_TNPR = 9'h118;
	localparam logic [8:0] OFS_TNCR = 9'h11c;
	localparam logic [8:0] OFS_PTCR = 9'h120;
	localparam logic [8:0] OFS_PTSR = 9'h124;
	localparam int CH_RX = 0, CH_TX = 1, CH_RXN = 2, CH_TXN = 3;

	logic [11:0] clk_mode;
	logic [31:0] mode_w [4];
	logic [31:0] holding;
	logic [15:0] sync_cmp [4];
	logic [31:0] mask;
	logic [31:0] ptr [4];
	logic [31:0] cnt [4];
	logic rx_on, tx_on, rx_dma, tx_dma, rx_pend, ovr, endrx, endtx, rearm;
	logic fetch_out;
	sscr_pkg::req_out_t pending_results[$];
	int errors;

	function new();
		errors = 0;
		clear();
	endfunction

	function void clear();
		clk_mode = '0;
		holding = '0;
		mask = '0;
		for (int i = 0; i < 4; i++) begin
			mode_w[i] = '0;
			sync_cmp[i] = '0;
			ptr[i] = '0;
			cnt[i] = '0;
		end
		{rx_on, tx_on, rx_dma, tx_dma, rx_pend, ovr, endrx, endtx, rearm} = '0;
		fetch_out = 1'b0;
	endfunction

	function logic [2:0] word_bytes(logic [31:0] fmr);
		int nbits;
		nbits = fmr[4:0] + 1;
		return nbits <= 8 ? 3'd1 : nbits <= 16 ? 3'd2 : 3'd4;
	endfunction

	function logic [31:0] keep_bytes(logic [2:0] n);
		return n == 3'd1 ? 32'hff : n == 3'd2 ? 32'hffff : 32'hffff_ffff;
	endfunction

	function logic [31:0] status();
		logic [31:0] s;
		s = 32'h3;
		s[2] = cnt[CH_TX] == 0 || endtx;
		s[3] = cnt[CH_TX] == 0 && cnt[CH_TXN] == 0;
		s[4] = rx_pend;
		s[5] = ovr;
		s[6] = cnt[CH_RX] == 0 || endrx;
		s[7] = cnt[CH_RX] == 0 && cnt[CH_RXN] == 0;
		s[16] = tx_on;
		s[17] = rx_on;
		return s;
	endfunction

	function void promote(int cur, int nxt, logic en);
		if (en && cnt[cur] == 0 && cnt[nxt] != 0) begin
			ptr[cur] = ptr[nxt];
			cnt[cur] = cnt[nxt];
			ptr[nxt] = '0;
			cnt[nxt] = '0;
		end
	endfunction

	function void receive(logic [31:0] w, ref sscr_pkg::req_out_t r);
		logic [2:0] n;
		n = word_bytes(mode_w[1]);
		if (!rx_on) return;
		promote(CH_RX, CH_RXN, rx_dma);
		if (rx_dma && cnt[CH_RX] != 0) begin
			r.mem_write_valid = 1'b1;
			r.mem_write_address = ptr[CH_RX];
			r.mem_write_data = w & keep_bytes(n);
			r.mem_write_bytes = n;
			ptr[CH_RX] += n;
			cnt[CH_RX] -= 1;
			if (cnt[CH_RX] == 0) begin
				endrx = 1'b1;
				promote(CH_RX, CH_RXN, rx_dma);
			end
		end else begin
			if (rx_pend) ovr = 1'b1;
			holding = w;
			rx_pend = 1'b1;
		end
	endfunction

	function logic tx_running();
		return tx_dma && tx_on && cnt[CH_TX] != 0;
	endfunction

	function logic [31:0] reg_read(logic [13:0] ofs);
		logic [31:0] v;
		v = '0;
		if (ofs[13:9] == 0) begin
			case (ofs[8:0])
				OFS_CMR: v = clk_mode;
				OFS_RCMR: v = mode_w[0];
				OFS_RFMR: v = mode_w[1];
				OFS_TCMR: v = mode_w[2];
				OFS_TFMR: v = mode_w[3];
				OFS_RHR: begin
					v = holding;
					rx_pend = 1'b0;
					ovr = 1'b0;
				end
				OFS_RSHR: v = sync_cmp[0];
				OFS_TSHR: v = sync_cmp[1];
				OFS_RC0R: v = sync_cmp[2];
				OFS_RC1R: v = sync_cmp[3];
				OFS_SR: begin
					v = status();
					{endrx, endtx, ovr} = '0;
				end
				OFS_IMR: v = mask;
				OFS_VER: v = 32'h100;
				OFS_RPR: v = ptr[0];
				OFS_RCR: v = cnt[0];
				OFS_TPR: v = ptr[1];
				OFS_TCR: v = cnt[1];
				OFS_RNPR: v = ptr[2];
				OFS_RNCR: v = cnt[2];
				OFS_TNPR: v = ptr[3];
				OFS_TNCR: v = cnt[3];
				OFS_PTSR: v = {23'd0, tx_dma, 7'd0, rx_dma};
				default: ;
			endcase
		end
		return v;
	endfunction

	function void reg_write(logic [13:0] ofs, logic [31:0] v, ref sscr_pkg::req_out_t r);
		if (ofs[13:9] != 0) return;
		case (ofs[8:0])
			OFS_CR: begin
				if (v[15]) clear();
				else begin
					if (v[0]) rx_on = 1'b1;
					if (v[1]) rx_on = 1'b0;
					if (v[8]) tx_on = 1'b1;
					if (v[9]) begin
						tx_on = 1'b0;
						rearm = 1'b0;
					end
				end
			end
			OFS_CMR: clk_mode = v[11:0];
			OFS_RCMR: mode_w[0] = v;
			OFS_RFMR: mode_w[1] = v;
			OFS_TCMR: mode_w[2] = v;
			OFS_TFMR: mode_w[3] = v;
			OFS_THR: if (tx_on) begin
				if (mode_w[1][5]) receive(v, r);
				rearm = 1'b1;
			end
			OFS_RSHR: sync_cmp[0] = v[15:0];
			OFS_TSHR: sync_cmp[1] = v[15:0];
			OFS_RC0R: sync_cmp[2] = v[15:0];
			OFS_RC1R: sync_cmp[3] = v[15:0];
			OFS_IER: mask |= v;
			OFS_IDR: mask &= ~v;
			OFS_RPR: ptr[0] = v;
			OFS_RCR: cnt[0] = v;
			OFS_TPR: ptr[1] = v;
			OFS_TCR: cnt[1] = v;
			OFS_RNPR: ptr[2] = v;
			OFS_RNCR: begin
				cnt[2] = v;
				promote(CH_RX, CH_RXN, rx_dma);
			end
			OFS_TNPR: ptr[3] = v;
			OFS_TNCR: cnt[3] = v;
			OFS_PTCR: begin
				if (v[0]) begin
					rx_dma = 1'b1;
					promote(CH_RX, CH_RXN, rx_dma);
				end
				if (v[1]) rx_dma = 1'b0;
				if (v[8]) tx_dma = 1'b1;
				if (v[9]) tx_dma = 1'b0;
			end
			default: ;
		endcase
	endfunction

	function void mem_return(logic [31:0] md, ref sscr_pkg::req_out_t r);
		logic [2:0] n;
		if (!fetch_out) return;
		fetch_out = 1'b0;
		if (!tx_running()) return;
		n = word_bytes(mode_w[3]);
		ptr[CH_TX] += n;
		cnt[CH_TX] -= 1;
		if (mode_w[1][5] && rx_on) receive(md & keep_bytes(n), r);
		if (cnt[CH_TX] == 0) begin
			endtx = 1'b1;
			promote(CH_TX, CH_TXN, tx_dma);
		end
	endfunction

	// note an accepted request and queue its expected result
	function void note_request(sscr_pkg::req_in_t q);
		sscr_pkg::req_out_t r;
		r = '0;
		rearm = 1'b0;
		case (q.action)
			sscr_pkg::ACT_READ: r.read_data = reg_read(q.offset);
			sscr_pkg::ACT_WRITE: reg_write(q.offset, q.write_data, r);
			sscr_pkg::ACT_MEM: mem_return(q.memory_data, r);
			default: ;
		endcase
		promote(CH_TX, CH_TXN, tx_dma);
		if (!fetch_out && tx_running()) begin
			r.mem_read_valid = 1'b1;
			r.mem_read_address = ptr[CH_TX];
			r.mem_read_bytes = word_bytes(mode_w[3]);
			fetch_out = 1'b1;
		end
		r.irq = (status() & mask) != 0;
		r.tx_dma_request = tx_on && !rearm && !rx_pend;
		r.rx_dma_request = rx_on && rx_pend;
		pending_results.push_back(r);
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h", what, got, want);
	endtask

	task check_result(sscr_pkg::req_out_t g);
		sscr_pkg::req_out_t e;
		if (pending_results.size() == 0) begin
			report("unexpected result", g.read_data, 0);
			return;
		end
		e = pending_results.pop_front();
		if (g.read_data !== e.read_data) report("read_data", g.read_data, e.read_data);
		if (g.irq !== e.irq) report("irq", g.irq, e.irq);
		if (g.tx_dma_request !== e.tx_dma_request)
			report("tx_dma_request", g.tx_dma_request, e.tx_dma_request);
		if (g.rx_dma_request !== e.rx_dma_request)
			report("rx_dma_request", g.rx_dma_request, e.rx_dma_request);
		if (g.mem_write_valid !== e.mem_write_valid)
			report("mem_write_valid", g.mem_write_valid, e.mem_write_valid);
		if (g.mem_write_address !== e.mem_write_address)
			report("mem_write_address", g.mem_write_address, e.mem_write_address);
		if (g.mem_write_data !== e.mem_write_data)
			report("mem_write_data", g.mem_write_data, e.mem_write_data);
		if (g.mem_write_bytes !== e.mem_write_bytes)
			report("mem_write_bytes", g.mem_write_bytes, e.mem_write_bytes);
		if (g.mem_read_valid !== e.mem_read_valid)
			report("mem_read_valid", g.mem_read_valid, e.mem_read_valid);
		if (g.mem_read_address !== e.mem_read_address)
			report("mem_read_address", g.mem_read_address, e.mem_read_address);
		if (g.mem_read_bytes !== e.mem_read_bytes)
			report("mem_read_bytes", g.mem_read_bytes, e.mem_read_bytes);
	endtask
endclass

/* tb/tb_top.sv */
// tb_top: random and directed test of the serial controller register block
// depends on sscr_pkg, sync_serial_ctrl_regs_pdc and sscr_scoreboard
module tb_top;
	import sscr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	req_out_t out_data;
	bit stim_done = 1'b0;
	sscr_scoreboard sb = new();

	// register offsets the stimulus aims at
	logic [8:0] reg_list [27] = '{REG_CR, REG_CMR, REG_RCMR, REG_RFMR, REG_TCMR, REG_TFMR,
		REG_RHR, REG_THR, REG_RSHR, REG_TSHR, REG_RC0R, REG_RC1R, REG_SR, REG_IER, REG_IDR,
		REG_IMR, REG_VER, REG_RPR, REG_RCR, REG_TPR, REG_TCR, REG_RNPR, REG_RNCR,
		REG_TNPR, REG_TNCR, REG_PTCR, REG_PTSR};

	sync_serial_ctrl_regs_pdc uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (in_valid && !in_stall) sb.note_request(in_data);
		if (out_valid && !out_stall) sb.check_result(out_data);
	end

	// valid stays high across back-to-back requests and drops only for a gap
	task automatic send(logic [1:0] act, logic [13:0] ofs, logic [31:0] wd, logic [31:0] md);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{action: act, offset: ofs, write_data: wd, memory_data: md};
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wr(logic [8:0] r, logic [31:0] v);
		send(ACT_WRITE, {5'd0, r}, v, $urandom);
	endtask

	task automatic rd(logic [8:0] r);
		send(ACT_READ, {5'd0, r}, $urandom, $urandom);
	endtask

	// a fresh transmit loop setup with random sizes and pointers
	task automatic setup_loop();
		wr(REG_CR, 32'h8000);
		wr(REG_RFMR, {$urandom} | 32'h20);
		wr(REG_TFMR, $urandom);
		wr(REG_IER, $urandom);
		wr(REG_TPR, $urandom);
		wr(REG_TCR, $urandom_range(1, 6));
		wr(REG_TNPR, $urandom);
		wr(REG_TNCR, $urandom_range(0, 4));
		wr(REG_RPR, $urandom);
		wr(REG_RCR, $urandom_range(0, 5));
		wr(REG_RNPR, $urandom);
		wr(REG_RNCR, $urandom_range(0, 4));
		wr(REG_PTCR, $urandom_range(0, 1) ? 32'h101 : 32'h100);
		wr(REG_CR, 32'h101);
	endtask

	task automatic random_item();
		int k;
		logic [31:0] v;
		k = $urandom_range(0, 99);
		v = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : $urandom;
		if (k < 40) send(ACT_MEM, 14'($urandom), $urandom, $urandom);
		else if (k < 60) rd(reg_list[$urandom_range(0, 26)]);
		else if (k < 70) wr(REG_THR, $urandom);
		else if (k < 88) wr(reg_list[$urandom_range(1, 26)], v);
		else if (k < 92) wr(REG_CR, $urandom & 32'h7fff);
		else if (k < 96) send(2'($urandom_range(0, 3)), 14'($urandom), $urandom, $urandom);
		else send(ACT_READ, $urandom_range(0, 3) == 0 ? 14'h3fff : 14'h0200,
			$urandom, $urandom);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, every action, unused action, software reset
		rd(REG_VER);
		rd(REG_SR);
		send(ACT_MEM, 14'h0, 32'h0, 32'hffff_ffff);
		send(2'd3, 14'h3fff, 32'hffff_ffff, 32'hffff_ffff);
		wr(REG_CMR, 32'hffff_ffff);
		wr(REG_RSHR, 32'hffff_ffff);
		wr(REG_TPR, 32'hffff_fffe);
		wr(REG_TCR, 32'h1);
		wr(REG_TNCR, 32'h2);
		wr(REG_TFMR, 32'h1f);
		wr(REG_RFMR, 32'h2f);
		wr(REG_CR, 32'h101);
		wr(REG_PTCR, 32'h303);
		wr(REG_PTCR, 32'h100);
		send(ACT_MEM, 14'h0, 32'h0, 32'hffff_ffff);
		wr(REG_THR, 32'h1234_5678);
		wr(REG_THR, 32'hffff_ffff);
		rd(REG_RHR);
		rd(REG_SR);
		wr(REG_CR, 32'h0000_0202);
		send(ACT_MEM, 14'h0, 32'h0, 32'hdead_beef);
		rd(REG_PTSR);
		wr(REG_CR, 32'hffff_ffff);
		rd(REG_CMR);
		for (int i = 0; i < 560; i++) begin
			if (i % 60 == 0) setup_loop();
			if (i == 300) begin
				// drain everything before going on
				in_valid <= 1'b0;
				@(posedge clk);
				wait (sb.pending_results.size() == 0);
				@(posedge clk);
			end
			random_item();
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		int w;
		forever begin
			w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		wait (stim_done);
		@(posedge clk);
		wait (sb.pending_results.size() == 0);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

	initial begin
		#2ms;
		$display("FAILURE");
		$finish;
	end
endmodule
